### hw/rtl/assert_macros.svh
// Assertion helper macros used by the checker file sprg_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
// Implication with the consequence checked in the next cycle.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`endif

### hw/rtl/sprg_pkg.sv
// ---------------------------------------------------------------------------
// sprg_pkg
// Shared constants and types of the stepper pulse ramp generator.
// ---------------------------------------------------------------------------
`default_nettype none
package sprg_pkg;
  localparam int unsigned TIMEBASE_HZ_DEF  = 32000000;
  localparam int unsigned PERIOD_LIMIT_DEF = 65000;
  localparam int unsigned FREQ_W  = 18;
  localparam int unsigned STEP_W  = 24;
  localparam int unsigned IN_W    = 88;  // 86 bits packed, padded to bytes
  localparam int unsigned OUT_W   = 32;
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;
  localparam logic [1:0] MS_8  = 2'd0;
  localparam logic [1:0] MS_16 = 2'd1;
  localparam logic [1:0] MS_32 = 2'd2;
  localparam logic [1:0] MS_64 = 2'd3;

  // Request to the divider unit.
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  // Response of the divider unit.
  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

### hw/rtl/stepper_pulse_ramp_generator.sv
// ---------------------------------------------------------------------------
// stepper_pulse_ramp_generator
// One stepper channel with a trapezoidal step frequency ramp.
// ---------------------------------------------------------------------------
// Usage: each input transfer is a tick (one timebase clock) or a move start.
// in_tdata carries all fields; every accepted item yields one result transfer
// carrying the pin levels, busy flag and completed step count.
// A tick with no rate change passes through ST_OUT to its result. A start,
// or a tick that ends a ramp step, runs the shared divider up to three
// times (ramp interpolation, prescaler, period); in_tready stays low
// meanwhile.
// Items are taken one at a time, in the steps accept, result register and
// result transfer, since in_tready is low until the result is taken.
// The result sits in an output register; while the receiver stalls
// out_tvalid holds and no new item is taken.
// Reset (synchronous, rst_n low) idles the channel, disables the driver,
// sets the period to PERIOD_LIMIT and prescale to 1, microstep mode 0.
// The microstep register is at byte address 0 of the cfg port.
// ---------------------------------------------------------------------------
`default_nettype none
module stepper_pulse_ramp_generator #(
  parameter int unsigned TIMEBASE_HZ  = sprg_pkg::TIMEBASE_HZ_DEF,
  parameter int unsigned PERIOD_LIMIT = sprg_pkg::PERIOD_LIMIT_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // operation, step_count, begin_freq, cruise_freq, ramp_steps, turn_dir
  input  wire logic [sprg_pkg::IN_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // step_pin, dir_pin, enable_pin_n, ms1_pin, ms2_pin, busy_res, steps_done
  output logic [sprg_pkg::OUT_W-1:0]      out_tdata,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [1:0]                 cfg_paddr,
  input  wire logic [31:0]                cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);
  import sprg_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_RAMP  = 7'b0000010,
    ST_RWAIT = 7'b0000100,
    ST_SCALE = 7'b0001000,
    ST_SWAIT = 7'b0010000,
    ST_PWAIT = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t st_r, st_nxt;
  div_req_t dreq;
  div_rsp_t drsp;

  logic [1:0]  ms_r;
  logic        run_r, pin_r, dir_r;
  logic [23:0] mv_r, acc_r;
  logic [24:0] tog_r;
  logic [17:0] lo_r, hi_r;
  logic [15:0] pl_r, pc_r;
  logic [7:0]  ps_r, psc_r;
  logic [17:0] f_r;       // frequency whose rate is being applied
  logic        ld_pc_r;   // reload period count after the rate update
  logic        neg_r;     // sign of the ramp product
  logic [7:0]  s_r;
  logic [31:0] out_r;
  logic        ov_r;

  // Input fields.
  logic        i_op, i_dir;
  logic [23:0] i_steps, i_ramp;
  logic [17:0] i_lo, i_hi;
  assign i_op    = in_tdata[0];
  assign i_steps = in_tdata[24:1];
  assign i_lo    = in_tdata[42:25];
  assign i_hi    = in_tdata[60:43];
  assign i_ramp  = in_tdata[84:61];
  assign i_dir   = in_tdata[85];

  assign in_tready  = (st_r == ST_IDLE) && !ov_r;
  assign out_tvalid = ov_r;
  assign out_tdata  = out_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {30'd0, ms_r};

  logic acc_in;
  assign acc_in = in_tvalid && in_tready;

  sprg_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // Tick arithmetic, done in the cycle the item is taken.
  logic        expire, tog_ev, fin;
  logic [7:0]  psc_inc;
  logic [24:0] tog_inc;
  logic [23:0] n_inc;
  logic        up_ph, dn_ph;
  logic [23:0] kmul;
  logic [18:0] dif;  // |hi-lo|
  logic        dneg;
  always_comb begin
    expire  = (pc_r <= 16'd1);
    psc_inc = psc_r + 8'd1;
    tog_ev  = expire && (psc_inc >= ps_r);
    tog_inc = tog_r + 25'd1;
    n_inc   = tog_inc[24:1];
    fin     = ({7'd0, tog_inc} >= {7'd0, mv_r, 1'b0});
    up_ph   = n_inc < acc_r;
    dn_ph   = {1'b0, n_inc} >= ({1'b0, mv_r} - {1'b0, acc_r});
    kmul    = up_ph ? n_inc : (mv_r - n_inc);
    dneg    = hi_r < lo_r;
    dif     = dneg ? {1'b0, lo_r} - {1'b0, hi_r} : {1'b0, hi_r} - {1'b0, lo_r};
  end

  // Sequencer and state registers.
  logic [63:0] prod;
  logic [31:0] ramp_f;
  logic [63:0] sc_q, pq;
  assign prod = {45'd0, dif} * {40'd0, kmul};
  always_comb begin
    // Signed interpolation result, truncated toward zero.
    ramp_f = neg_r ? {14'd0, lo_r} - drsp.quotient[31:0]
                   : {14'd0, lo_r} + drsp.quotient[31:0];
    sc_q   = drsp.quotient + 64'd1;
    pq     = drsp.quotient;
  end

  always_comb begin
    st_nxt        = st_r;
    dreq.start    = 1'b0;
    dreq.dividend = '0;
    dreq.divisor  = 64'd1;
    case (st_r)
      ST_IDLE: begin
        if (acc_in) st_nxt = ST_OUT;
        if (acc_in && i_op == OP_START && !run_r && i_steps != '0 && i_lo != '0)
          st_nxt = ST_SCALE;
        if (acc_in && i_op == OP_TICK && run_r && tog_ev && !tog_inc[0] &&
            acc_r != '0) begin
          if (up_ph || dn_ph) begin
            st_nxt        = ST_RWAIT;
            dreq.start    = 1'b1;
            dreq.dividend = prod;
            dreq.divisor  = {40'd0, acc_r};
          end else if (hi_r != '0) begin
            st_nxt = ST_SCALE;
          end
        end
      end
      ST_RWAIT: begin
        if (drsp.done) begin
          if (!ramp_f[31] && ramp_f != '0) st_nxt = ST_SCALE;
          else st_nxt = ST_OUT;
        end
      end
      ST_SCALE: begin
        st_nxt        = ST_SWAIT;
        dreq.start    = 1'b1;
        dreq.dividend = 64'(TIMEBASE_HZ);
        dreq.divisor  = {46'd0, f_r} * 64'(2 * (PERIOD_LIMIT + 1));
      end
      ST_SWAIT: begin
        if (drsp.done) begin
          st_nxt        = ST_RAMP;
        end
      end
      ST_RAMP: begin
        st_nxt        = ST_PWAIT;
        dreq.start    = 1'b1;
        dreq.dividend = 64'(TIMEBASE_HZ);
        dreq.divisor  = {45'd0, f_r, 1'b0} * {56'd0, s_r};
      end
      ST_PWAIT: begin
        if (drsp.done) st_nxt = ST_OUT;
      end
      ST_OUT: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      ms_r  <= MS_8;
      run_r <= 1'b0; pin_r <= 1'b0; dir_r <= 1'b0;
      mv_r  <= '0; tog_r <= '0; lo_r <= '0; hi_r <= '0; acc_r <= '0;
      pl_r  <= 16'(PERIOD_LIMIT); ps_r <= 8'd1; psc_r <= '0; pc_r <= '0;
      ov_r  <= 1'b0; ld_pc_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0)
        ms_r <= cfg_pwdata[1:0];
      if (ov_r && out_tready) ov_r <= 1'b0;
      if (st_r == ST_IDLE && acc_in) begin
        ld_pc_r <= (i_op == OP_START) && !run_r && (i_steps != '0);
        if (i_op == OP_START) begin
          if (!run_r && i_steps != '0) begin
            mv_r    <= i_steps;
            tog_r   <= '0;
            lo_r    <= i_lo;
            hi_r    <= i_hi;
            acc_r   <= ({1'b0, i_ramp} > {1'b0, i_steps[23:1]}) ? i_steps >> 1 : i_ramp;
            dir_r   <= i_dir;
            run_r   <= 1'b1;
            f_r     <= i_lo;
            pc_r    <= pl_r;
          end
        end else if (run_r) begin
          if (expire) begin
            pc_r <= pl_r;
            if (tog_ev) begin
              psc_r <= '0;
              pin_r <= fin ? 1'b0 : ~pin_r;
              tog_r <= tog_inc;
              if (fin) run_r <= 1'b0;
              f_r   <= hi_r;
              neg_r <= dneg;
            end else begin
              psc_r <= psc_inc;
            end
          end else begin
            pc_r <= pc_r - 16'd1;
          end
        end
      end
      if (st_r == ST_RWAIT && drsp.done) f_r <= ramp_f[17:0];
      if (st_r == ST_SWAIT && drsp.done)
        s_r <= (sc_q > 64'd255) ? 8'd255 : sc_q[7:0];
      if (st_r == ST_PWAIT && drsp.done) begin
        ps_r <= s_r;
        if (pq > 64'(PERIOD_LIMIT)) begin
          pl_r <= 16'(PERIOD_LIMIT);
          if (ld_pc_r) pc_r <= 16'(PERIOD_LIMIT);
        end else if (pq == '0) begin
          pl_r <= 16'd1;
          if (ld_pc_r) pc_r <= 16'd1;
        end else begin
          pl_r <= pq[15:0];
          if (ld_pc_r) pc_r <= pq[15:0];
        end
      end
      if (st_r == ST_OUT) ov_r <= 1'b1;
    end
    if (st_r == ST_OUT) begin
      out_r <= {2'd0, tog_r[24:1], run_r,
                (ms_r == MS_16 || ms_r == MS_64),
                (ms_r == MS_16 || ms_r == MS_32),
                ~run_r, dir_r, pin_r};
    end
  end
endmodule
`default_nettype wire

### hw/rtl/sprg_div.sv
// ---------------------------------------------------------------------------
// sprg_div
// Radix-2 restoring divider of 64-bit operands, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module sprg_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sprg_pkg::div_req_t req,
  output sprg_pkg::div_rsp_t      rsp
);
  import sprg_pkg::*;
  logic [63:0] quo_r, quo_nxt, den_r, den_nxt;
  logic [64:0] rem_r, rem_nxt, trial;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;

  // Shift in one dividend bit and try the subtraction.
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[63:0], quo_r[63]} - {1'b0, den_r};
    if (req.start) begin
      quo_nxt  = req.dividend;
      den_nxt  = req.divisor;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial[64]) begin
        rem_nxt = {rem_r[63:0], quo_r[63]};
        quo_nxt = {quo_r[62:0], 1'b0};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[62:0], 1'b1};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;
endmodule
`default_nettype wire

### hw/rtl/sprg_checker.sv
// ---------------------------------------------------------------------------
// sprg_checker
// Port-level checks of the stepper pulse ramp generator.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module sprg_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        cfg_pready
);
  // Busy and enable_pin_n are complementary.
  `CHK_IMPL(a_en, clk, rst_n, out_tvalid, out_tdata[2] != out_tdata[5])
  // Not ready while a result waits.
  `CHK_IMPL(a_rdy, clk, rst_n, out_tvalid, !in_tready)
  // Step pin is low whenever the channel is idle.
  `CHK_IMPL(a_pin, clk, rst_n, out_tvalid && !out_tdata[5], !out_tdata[0])
  // A stalled result holds.
  `CHK_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // The configuration port never stalls.
  `CHK_IMPL(a_prdy, clk, rst_n, 1'b1, cfg_pready)
endmodule

bind stepper_pulse_ramp_generator sprg_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .cfg_pready(cfg_pready)
);
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking testbench for the stepper pulse ramp generator. Moves are
// started with short step counts at high step rates so that each one runs to
// completion. A cycle-free predictor tracks the period counter, the prescaler
// and the ramp, and every result transfer is compared field by field with the
// predicted pin levels and step count. Both stream sides insert random gaps.
// ---------------------------------------------------------------------------
`default_nettype none
module tb;
  import sprg_pkg::*;

  localparam longint CLK_HZ = 32000000;
  localparam longint PLIM   = 65000;

  // Pin levels and counters carried by one result transfer.
  typedef struct {
    logic        step_pin;
    logic        dir_pin;
    logic        enable_pin_n;
    logic        ms1_pin;
    logic        ms2_pin;
    logic        busy;
    logic [23:0] steps_done;
  } pins_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  // op, step_count, begin_freq, cruise_freq, ramp_steps, turn_dir, zero pad
  logic [IN_W-1:0]   in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  // step_pin, dir_pin, enable_pin_n, ms1, ms2, busy, steps_done, zero pad
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [1:0]        cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  stepper_pulse_ramp_generator uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Channel state mirrored by the predictor.
  logic        m_run, m_pin, m_dir;
  logic [23:0] m_steps, m_accel;
  logic [24:0] m_toggles;
  logic [17:0] m_lo, m_hi;
  logic [15:0] m_pload, m_pcount;
  logic [7:0]  m_psc, m_pscnt;
  logic [1:0]  m_ms;

  pins_t  pins_expected[$];
  int     errors = 0;
  int     items_sent = 0;
  int     moves_done = 0;
  int     results_seen = 0;
  bit     quiet = 1'b0;

  // Recompute prescaler and reload value for a step frequency.
  function automatic void set_rate(longint f);
    longint s, p;
    if (f == 0) return;
    s = CLK_HZ / (2 * f * (PLIM + 1)) + 1;
    if (s > 255) s = 255;
    p = CLK_HZ / (2 * f * s);
    if (p > PLIM) p = PLIM;
    if (p == 0) p = 1;
    m_psc   = s[7:0];
    m_pload = p[15:0];
  endfunction

  // One step-pin toggle, with the ramp update on each full step.
  function automatic void toggle_pin();
    longint lo, hi, f, n, k;
    m_pin = ~m_pin;
    m_toggles = m_toggles + 25'd1;
    n = longint'(m_toggles >> 1);
    if (m_accel != 0 && !m_toggles[0]) begin
      lo = longint'(m_lo);
      hi = longint'(m_hi);
      f  = hi;
      if (n < longint'(m_accel)) begin
        f = lo + (hi - lo) * n / longint'(m_accel);
      end else if (n >= longint'(m_steps) - longint'(m_accel)) begin
        k = longint'(m_steps) - n;
        f = lo + (hi - lo) * k / longint'(m_accel);
      end
      if (f > 0) set_rate(f);
    end
    if (longint'(m_toggles) >= 2 * longint'(m_steps)) begin
      m_run = 1'b0;
      m_pin = 1'b0;
      moves_done++;
    end
  endfunction

  // Advance the channel by one accepted item and queue its pin levels.
  function automatic void predict_pins(logic [IN_W-1:0] d);
    pins_t r;
    logic [23:0] steps, ramp;
    steps = d[24:1];
    ramp  = d[84:61];
    if (d[0] == OP_START) begin
      if (!m_run && steps != 0) begin
        m_steps   = steps;
        m_toggles = '0;
        m_lo      = d[42:25];
        m_hi      = d[60:43];
        m_accel   = (25'(ramp) * 2 > 25'(steps)) ? steps / 2 : ramp;
        m_dir     = d[85];
        m_run     = 1'b1;
        set_rate(longint'(m_lo));
        m_pcount  = m_pload;
      end
    end else if (m_run) begin
      if (m_pcount <= 1) begin
        m_pcount = m_pload;
        m_pscnt  = m_pscnt + 8'd1;
        if (m_pscnt >= m_psc) begin
          m_pscnt = '0;
          toggle_pin();
        end
      end else begin
        m_pcount = m_pcount - 16'd1;
      end
    end
    r.step_pin     = m_pin;
    r.dir_pin      = m_dir;
    r.enable_pin_n = ~m_run;
    r.ms1_pin      = (m_ms == MS_16 || m_ms == MS_32);
    r.ms2_pin      = (m_ms == MS_16 || m_ms == MS_64);
    r.busy         = m_run;
    r.steps_done   = m_toggles[24:1];
    pins_expected.push_back(r);
  endfunction

  // Send one item after a random gap and predict it on acceptance.
  task automatic send_item(logic op, logic [23:0] steps, logic [17:0] lo,
                           logic [17:0] hi, logic [23:0] ramp, logic dir);
    int gap;
    logic [IN_W-1:0] d;
    d = {2'b00, dir, ramp, hi, lo, steps, op};
    gap = quiet ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    predict_pins(d);
    items_sent++;
  endtask

  // Tick item with random content in the unused fields.
  task automatic send_tick();
    send_item(OP_TICK, 24'($urandom), 18'($urandom), 18'($urandom),
              24'($urandom), 1'($urandom));
  endtask

  // Start item with random fields (frequencies up to 250000), expected to be ignored while busy.
  task automatic send_noise_start();
    send_item(OP_START, 24'($urandom), 18'($urandom_range(0, 250000)),
              18'($urandom_range(0, 250000)), 24'($urandom), 1'($urandom));
  endtask

  // Tick until the predicted move has ended, with optional stray starts.
  task automatic tick_to_end(bit noise);
    while (m_run) begin
      if (noise && $urandom_range(0, 19) == 0) send_noise_start();
      else send_tick();
    end
  endtask

  task automatic run_move(logic [23:0] steps, logic [17:0] lo, logic [17:0] hi,
                          logic [23:0] ramp, logic dir, bit noise);
    send_item(OP_START, steps, lo, hi, ramp, dir);
    tick_to_end(noise);
  endtask

  // Wait until every result is in and the divider has settled.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pins_expected.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  // APB write followed by a read-back of the microstep register.
  task automatic write_mode(logic [1:0] mode);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= 2'd0;
    cfg_pwdata <= {30'd0, mode}; cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    m_ms = mode;
    @(negedge clk);
    cfg_pwrite <= 1'b0; cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[1:0] !== mode) begin
      errors++;
      if (errors <= 10)
        $display("Register read-back: expected %0d, got %0d", mode, cfg_prdata[1:0]);
    end
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0;
  endtask

  // Receiver: random stalls before each result transfer.
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 6);
      repeat (stall) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    pins_t e;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pins_expected.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result transfer: %h", out_tdata);
      end else begin
        e = pins_expected.pop_front();
        if (out_tdata[0] !== e.step_pin || out_tdata[1] !== e.dir_pin ||
            out_tdata[2] !== e.enable_pin_n || out_tdata[3] !== e.ms1_pin ||
            out_tdata[4] !== e.ms2_pin || out_tdata[5] !== e.busy ||
            out_tdata[29:6] !== e.steps_done) begin
          errors++;
          if (errors <= 10)
            $display({"Result %0d: expected step=%b dir=%b en_n=%b ms=%b%b ",
                      "busy=%b done=%0d, got step=%b dir=%b en_n=%b ms=%b%b ",
                      "busy=%b done=%0d"},
                     results_seen, e.step_pin, e.dir_pin, e.enable_pin_n,
                     e.ms1_pin, e.ms2_pin, e.busy, e.steps_done,
                     out_tdata[0], out_tdata[1], out_tdata[2], out_tdata[3],
                     out_tdata[4], out_tdata[5], out_tdata[29:6]);
        end
      end
    end
  end

  task automatic test_idle_ticks();
    repeat (4) send_tick();
    send_item(OP_START, 24'd0, 18'd250000, 18'd250000, 24'hFFFFFF, 1'b1);
    drain();
  endtask

  task automatic test_microstep_modes();
    write_mode(MS_64);
    repeat (2) send_tick();
    drain();
    write_mode(MS_32);
    repeat (2) send_tick();
    drain();
    write_mode(MS_16);
    repeat (2) send_tick();
    drain();
  endtask

  task automatic test_directed_moves();
    // Ramp up then down, with the ramp length clamped to half the move.
    run_move(24'd4, 18'd240000, 18'd250000, 24'hFFFFFF, 1'b1, 1'b0);
    // Zero start frequency keeps the previous period, and the ramp ending at
    // zero frequency leaves the rate unchanged. A second start while the
    // move runs is ignored.
    send_item(OP_START, 24'd2, 18'd0, 18'd200000, 24'd1, 1'b0);
    send_item(OP_START, 24'hFFFFFF, 18'd250000, 18'd250000, 24'hFFFFFF, 1'b1);
    tick_to_end(1'b0);
    drain();
    write_mode(MS_8);
  endtask

  task automatic test_random_moves();
    int phase;
    phase = 0;
    while (items_sent < 950) begin
      quiet = ($urandom_range(0, 3) == 0);
      run_move(24'($urandom_range(1, 2)), 18'($urandom_range(0, 9) == 0 ? 0 :
               $urandom_range(200000, 250000)), 18'($urandom_range(200000, 250000)),
               $urandom_range(0, 1) ? 24'($urandom_range(0, 2)) : 24'($urandom),
               1'($urandom), 1'b1);
      if ($urandom_range(0, 3) == 0) send_tick();
      phase++;
      if (phase % 3 == 0) begin
        quiet = 1'b0;
        drain();
        write_mode(2'($urandom));
      end
    end
    quiet = 1'b0;
    drain();
  endtask

  initial begin
    m_run = 0; m_pin = 0; m_dir = 0; m_steps = 0; m_toggles = 0;
    m_lo = 0; m_hi = 0; m_accel = 0; m_pload = 16'(PLIM); m_psc = 8'd1;
    m_pscnt = 0; m_pcount = 0; m_ms = MS_8;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_idle_ticks();
    test_microstep_modes();
    test_directed_moves();
    test_random_moves();
    $display("Sent %0d items and checked %0d results over %0d completed moves,",
             items_sent, results_seen, moves_done);
    $display("with all four microstep modes and random gaps on both sides.");
    if (errors == 0) begin
      $display("stepper_pulse_ramp_generator test passed");
    end else begin
      $display("Mismatches: %0d", errors);
      $display("stepper_pulse_ramp_generator test failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #20000000;
    $display("Timeout with %0d results outstanding", pins_expected.size());
    $display("stepper_pulse_ramp_generator test failed");
    $finish;
  end
endmodule
`default_nettype wire
